### src/crlr_pkg.sv
// Package for the clipped line rasterizer: payload structs, queue entry,
// config bundle, back-end state type and fixed widths. No dependencies.
`default_nettype none
package crlr_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 16;
  localparam int COLOR_BITS = 16;
  localparam int SIZE_BITS  = 11;
  localparam int FIX_W      = COORD_BITS + FRAC_BITS + 2;
  localparam int INC_W      = FRAC_BITS + 2;
  localparam int ERR_W      = COORD_BITS + 4;
  localparam int DIV_W      = COORD_BITS + FRAC_BITS;

  // configuration register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MODE   = 2'd2;

  // action codes
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_STEP = 1'b1;

  // line mode codes
  localparam logic MODE_DDA  = 1'b0;
  localparam logic MODE_BRES = 1'b1;

  typedef struct packed {
    logic                         action;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic [COLOR_BITS-1:0]        pen_color;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic [COLOR_BITS-1:0]        pixel_color;
    logic                         on_screen;
    logic                         last_pixel;
    logic                         pixel_present;
  } out_item_t;

  // classified command held in the queue
  typedef struct packed {
    logic                         is_step;
    logic signed [COORD_BITS-1:0] x0;
    logic signed [COORD_BITS-1:0] y0;
    logic signed [COORD_BITS-1:0] x1;
    logic signed [COORD_BITS-1:0] y1;
    logic signed [COORD_BITS:0]   dx;
    logic signed [COORD_BITS:0]   dy;
    logic [COORD_BITS-1:0]        adx;
    logic [COORD_BITS-1:0]        ady;
    logic [COLOR_BITS-1:0]        color;
  } cmd_t;

  typedef struct packed {
    logic [SIZE_BITS-1:0] width;
    logic [SIZE_BITS-1:0] height;
    logic                 mode;
    logic                 mode_wr;
  } cfg_t;

  typedef enum logic {
    BK_RUN,
    BK_DIV
  } bk_state_t;

endpackage
`default_nettype wire

### src/crlr_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on crlr_pkg for widths.
`default_nettype none
module crlr_div (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [crlr_pkg::DIV_W-1:0]     dividend,
  input  wire logic [crlr_pkg::COORD_BITS-1:0] divisor,
  output logic                                done,
  output logic [crlr_pkg::DIV_W-1:0]          quotient
);
  import crlr_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [COORD_BITS:0]   rem_r, rem_nxt;
  logic [DIV_W-1:0]      quo_r, quo_nxt;
  logic [COORD_BITS-1:0] div_r;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [COORD_BITS:0]   trial;
  logic                  fits;

  // shift in one dividend bit and try a subtract
  always_comb begin
    trial    = {rem_r[COORD_BITS-1:0], quo_r[DIV_W-1]};
    fits     = trial >= {1'b0, div_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? trial - {1'b0, div_r} : trial;
      quo_nxt = {quo_r[DIV_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) div_r <= divisor;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

### src/crlr_front.sv
// Front end: accepts input items, classifies them into commands and queues
// them in a two-entry queue. Depends on crlr_pkg.
`default_nettype none
module crlr_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire crlr_pkg::in_item_t in_data,
  output logic                    q_valid,
  output crlr_pkg::cmd_t          q_head,
  input  wire logic               q_pop
);
  import crlr_pkg::*;

  cmd_t       ent_r [2];
  logic       wr_r, wr_nxt;
  logic       rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  cmd_t       cmd;

  // classify: deltas and their magnitudes
  always_comb begin
    cmd.is_step = in_data.action == ACT_STEP;
    cmd.x0      = in_data.start_x;
    cmd.y0      = in_data.start_y;
    cmd.x1      = in_data.end_x;
    cmd.y1      = in_data.end_y;
    cmd.dx      = {in_data.end_x[COORD_BITS-1], in_data.end_x}
                - {in_data.start_x[COORD_BITS-1], in_data.start_x};
    cmd.dy      = {in_data.end_y[COORD_BITS-1], in_data.end_y}
                - {in_data.start_y[COORD_BITS-1], in_data.start_y};
    cmd.adx     = cmd.dx[COORD_BITS] ? COORD_BITS'(-cmd.dx) : cmd.dx[COORD_BITS-1:0];
    cmd.ady     = cmd.dy[COORD_BITS] ? COORD_BITS'(-cmd.dy) : cmd.dy[COORD_BITS-1:0];
    cmd.color   = in_data.pen_color;
  end

  assign in_stall = cnt_r == 2'd2;
  assign push     = in_valid && !in_stall;
  assign q_valid  = cnt_r != 2'd0;
  assign q_head   = ent_r[rd_r];

  // advance queue pointers
  always_comb begin
    wr_nxt  = push ? !wr_r : wr_r;
    rd_nxt  = q_pop ? !rd_r : rd_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) ent_r[wr_r] <= cmd;
  end

endmodule
`default_nettype wire

### src/crlr_back.sv
// Back end: carries out queued commands (line setup, DDA division, pixel
// steps) and holds the output register. Depends on crlr_pkg and crlr_div.
`default_nettype none
module crlr_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire crlr_pkg::cfg_t      cfg,
  input  wire logic                q_valid,
  input  wire crlr_pkg::cmd_t      q_head,
  output logic                     q_pop,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output crlr_pkg::out_item_t      out_data
);
  import crlr_pkg::*;

  localparam logic [FIX_W-1:0] HALF = FIX_W'(1) << (FRAC_BITS - 1);

  bk_state_t state_r, state_nxt;

  logic                         active_r, active_nxt;
  logic signed [COORD_BITS-1:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic signed [COORD_BITS-1:0] stop_r, stop_nxt;
  logic signed [ERR_W-1:0]      err_r, err_nxt;
  logic [COORD_BITS-1:0]        adx_r, adx_nxt, ady_r, ady_nxt;
  logic                         up_r, up_nxt, xmaj_r, xmaj_nxt;
  logic signed [FIX_W-1:0]      frac_x_r, frac_x_nxt, frac_y_r, frac_y_nxt;
  logic signed [INC_W-1:0]      inc_x_r, inc_x_nxt, inc_y_r, inc_y_nxt;
  logic [COORD_BITS-1:0]        steps_r, steps_nxt;
  logic [COLOR_BITS-1:0]        color_r, color_nxt;
  logic                         neg_x_r, neg_x_nxt, neg_y_r, neg_y_nxt;
  out_item_t                    out_r, out_nxt;
  logic                         out_valid_r, out_valid_nxt;

  logic                  out_free;
  logic                  div_start;
  logic                  div_done;
  logic [DIV_W-1:0]      quo_x, quo_y;
  logic [COORD_BITS-1:0] steps_new;

  logic signed [COORD_BITS-1:0] px, py;
  logic                         last;
  logic [FIX_W-1:0]             mag_x, mag_y, rnd_x, rnd_y;
  logic signed [COORD_BITS:0]   dd;
  logic [ERR_W-1:0]             two_adx, two_ady;
  logic signed [ERR_W-1:0]      two_diff;
  logic                         fwd;
  logic signed [INC_W-1:0]      qx, qy;

  assign out_free  = !out_valid_r || !out_stall;
  assign steps_new = (q_head.adx >= q_head.ady) ? q_head.adx : q_head.ady;

  crlr_div u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({q_head.adx, {FRAC_BITS{1'b0}}}),
    .divisor  (steps_new),
    .done     (div_done),
    .quotient (quo_x)
  );

  crlr_div u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({q_head.ady, {FRAC_BITS{1'b0}}}),
    .divisor  (steps_new),
    .done     (),
    .quotient (quo_y)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_RUN: if (div_start) state_nxt = BK_DIV;
      BK_DIV: if (div_done) state_nxt = BK_RUN;
      default: state_nxt = BK_RUN;
    endcase
  end

  // pop when running and the command can complete this cycle
  always_comb begin
    q_pop = (state_r == BK_RUN) && q_valid && (!q_head.is_step || out_free);
    div_start = q_pop && !q_head.is_step && (cfg.mode == MODE_DDA) &&
                (steps_new != '0);
  end

  // current pixel and step arithmetic
  always_comb begin
    mag_x = frac_x_r[FIX_W-1] ? FIX_W'(-frac_x_r) : frac_x_r;
    mag_y = frac_y_r[FIX_W-1] ? FIX_W'(-frac_y_r) : frac_y_r;
    rnd_x = (mag_x + HALF) >> FRAC_BITS;
    rnd_y = (mag_y + HALF) >> FRAC_BITS;
    if (cfg.mode == MODE_DDA) begin
      px   = frac_x_r[FIX_W-1] ? -rnd_x[COORD_BITS-1:0] : rnd_x[COORD_BITS-1:0];
      py   = frac_y_r[FIX_W-1] ? -rnd_y[COORD_BITS-1:0] : rnd_y[COORD_BITS-1:0];
      last = steps_r <= COORD_BITS'(1);
    end else begin
      px   = cur_x_r;
      py   = cur_y_r;
      last = xmaj_r ? (cur_x_r == stop_r) : (cur_y_r == stop_r);
    end
    two_adx = {{(ERR_W-COORD_BITS-1){1'b0}}, adx_r, 1'b0};
    two_ady = {{(ERR_W-COORD_BITS-1){1'b0}}, ady_r, 1'b0};
    dd      = xmaj_r ? ({1'b0, ady_r} - {1'b0, adx_r}) : ({1'b0, adx_r} - {1'b0, ady_r});
    two_diff = {{(ERR_W-COORD_BITS-2){dd[COORD_BITS]}}, dd, 1'b0};
    fwd     = (q_head.ady <= q_head.adx) ? !q_head.dx[COORD_BITS] : !q_head.dy[COORD_BITS];
    qx      = {1'b0, quo_x[INC_W-2:0]};
    qy      = {1'b0, quo_y[INC_W-2:0]};
  end

  // datapath updates
  always_comb begin
    active_nxt    = active_r;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    stop_nxt      = stop_r;
    err_nxt       = err_r;
    adx_nxt       = adx_r;
    ady_nxt       = ady_r;
    up_nxt        = up_r;
    xmaj_nxt      = xmaj_r;
    frac_x_nxt    = frac_x_r;
    frac_y_nxt    = frac_y_r;
    inc_x_nxt     = inc_x_r;
    inc_y_nxt     = inc_y_r;
    steps_nxt     = steps_r;
    color_nxt     = color_r;
    neg_x_nxt     = neg_x_r;
    neg_y_nxt     = neg_y_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;

    if (state_r == BK_DIV && div_done) begin
      inc_x_nxt  = neg_x_r ? -qx : qx;
      inc_y_nxt  = neg_y_r ? -qy : qy;
      active_nxt = 1'b1;
    end

    if (q_pop && !q_head.is_step) begin
      // set up a new line
      color_nxt = q_head.color;
      adx_nxt   = q_head.adx;
      ady_nxt   = q_head.ady;
      if (cfg.mode == MODE_DDA) begin
        steps_nxt  = steps_new;
        active_nxt = 1'b0;
        neg_x_nxt  = q_head.dx[COORD_BITS];
        neg_y_nxt  = q_head.dy[COORD_BITS];
        frac_x_nxt = {{(FIX_W-COORD_BITS-FRAC_BITS){q_head.x0[COORD_BITS-1]}},
                      q_head.x0, {FRAC_BITS{1'b0}}};
        frac_y_nxt = {{(FIX_W-COORD_BITS-FRAC_BITS){q_head.y0[COORD_BITS-1]}},
                      q_head.y0, {FRAC_BITS{1'b0}}};
      end else begin
        up_nxt   = (q_head.dx[COORD_BITS] && q_head.dy[COORD_BITS]) ||
                   (!q_head.dx[COORD_BITS] && q_head.dx != '0 &&
                    !q_head.dy[COORD_BITS] && q_head.dy != '0);
        xmaj_nxt = q_head.ady <= q_head.adx;
        cur_x_nxt = fwd ? q_head.x0 : q_head.x1;
        cur_y_nxt = fwd ? q_head.y0 : q_head.y1;
        if (q_head.ady <= q_head.adx) begin
          stop_nxt = fwd ? q_head.x1 : q_head.x0;
          err_nxt  = $signed({{(ERR_W-COORD_BITS-1){1'b0}}, q_head.ady, 1'b0}
                   - {{(ERR_W-COORD_BITS){1'b0}}, q_head.adx});
        end else begin
          stop_nxt = fwd ? q_head.y1 : q_head.y0;
          err_nxt  = $signed({{(ERR_W-COORD_BITS-1){1'b0}}, q_head.adx, 1'b0}
                   - {{(ERR_W-COORD_BITS){1'b0}}, q_head.ady});
        end
        active_nxt = 1'b1;
      end
    end else if (q_pop) begin
      // emit one output item (a pixel when a line is active) and advance
      out_valid_nxt = 1'b1;
      out_nxt       = '0;
      if (active_r) begin
        out_nxt.pixel_x       = px;
        out_nxt.pixel_y       = py;
        out_nxt.pixel_color   = color_r;
        out_nxt.on_screen     = !px[COORD_BITS-1] && (px[COORD_BITS-2:0] < cfg.width) &&
                                !py[COORD_BITS-1] && (py[COORD_BITS-2:0] < cfg.height);
        out_nxt.last_pixel    = last;
        out_nxt.pixel_present = 1'b1;
        if (last) active_nxt = 1'b0;
        if (cfg.mode == MODE_DDA) begin
          frac_x_nxt = frac_x_r + {{(FIX_W-INC_W){inc_x_r[INC_W-1]}}, inc_x_r};
          frac_y_nxt = frac_y_r + {{(FIX_W-INC_W){inc_y_r[INC_W-1]}}, inc_y_r};
          steps_nxt  = steps_r - 1'b1;
        end else if (!last) begin
          if (xmaj_r) begin
            cur_x_nxt = cur_x_r + 1'b1;
            if (err_r < 0) begin
              err_nxt = err_r + $signed(two_ady);
            end else begin
              cur_y_nxt = up_r ? cur_y_r + 1'b1 : cur_y_r - 1'b1;
              err_nxt   = err_r + two_diff;
            end
          end else begin
            cur_y_nxt = cur_y_r + 1'b1;
            if (err_r <= 0) begin
              err_nxt = err_r + $signed(two_adx);
            end else begin
              cur_x_nxt = up_r ? cur_x_r + 1'b1 : cur_x_r - 1'b1;
              err_nxt   = err_r + two_diff;
            end
          end
        end
      end
    end

    // drop the pending line on a mode write
    if (cfg.mode_wr) active_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_RUN;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_x_r  <= cur_x_nxt;
    cur_y_r  <= cur_y_nxt;
    stop_r   <= stop_nxt;
    err_r    <= err_nxt;
    adx_r    <= adx_nxt;
    ady_r    <= ady_nxt;
    up_r     <= up_nxt;
    xmaj_r   <= xmaj_nxt;
    frac_x_r <= frac_x_nxt;
    frac_y_r <= frac_y_nxt;
    inc_x_r  <= inc_x_nxt;
    inc_y_r  <= inc_y_nxt;
    steps_r  <= steps_nxt;
    color_r  <= color_nxt;
    neg_x_r  <= neg_x_nxt;
    neg_y_r  <= neg_y_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

### src/clipped_line_rasterizer.sv
// Clipped line rasterizer: a step request returns one output item (a pixel if
// a line is active) via the queue entry and output register; one request per
// cycle is sustained from the two-entry queue while out_stall is low and no
// DDA load holds the back end in BK_DIV as the serial dividers form the
// increments; Bresenham loads do not. Synchronous active-low reset: no line
// pending, queue and output empty, width 320, height 240, Bresenham mode.
`default_nettype none
module clipped_line_rasterizer (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire crlr_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output crlr_pkg::out_item_t       out_data,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [crlr_pkg::SIZE_BITS-1:0] cfg_data
);
  import crlr_pkg::*;

  logic [SIZE_BITS-1:0] width_r, height_r;
  logic                 mode_r;
  cfg_t                 cfg;
  logic                 q_valid, q_pop;
  cmd_t                 q_head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SIZE_BITS'(320);
      height_r <= SIZE_BITS'(240);
      mode_r   <= MODE_BRES;
    end else if (cfg_we) begin
      if (cfg_index == REG_WIDTH)  width_r  <= cfg_data;
      if (cfg_index == REG_HEIGHT) height_r <= cfg_data;
      if (cfg_index == REG_MODE)   mode_r   <= cfg_data[0];
    end
  end

  always_comb begin
    cfg.width   = width_r;
    cfg.height  = height_r;
    cfg.mode    = mode_r;
    cfg.mode_wr = cfg_we && (cfg_index == REG_MODE);
  end

  crlr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop)
  );

  crlr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
